FILE: hdl/lae_pkg.sv
// ---------------------------------------------------------------------------
// lae_pkg - shared types and constants for the life automaton engine
// Grid size, field widths, command codes, transfer structs and controller
// state type.
// ---------------------------------------------------------------------------
`default_nettype none

package lae_pkg;

    localparam int GRID_SIZE = 40;              // rows and columns, 3 .. 64
    localparam int ROW_W     = GRID_SIZE;       // stored bits per row
    localparam int ADDR_W    = $clog2(GRID_SIZE);
    localparam int CNT_W     = $clog2(GRID_SIZE + 2);
    localparam int IDX_W     = 6;
    localparam int OUT_W     = 40;
    localparam int WIDE_W    = (ROW_W > OUT_W) ? ROW_W : OUT_W;

    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] cell_row;
        logic [IDX_W-1:0] cell_col;
    } cmd_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [OUT_W-1:0] row_cells;
        logic             last_row;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              read_en;
        logic [ADDR_W-1:0] read_addr;
        logic              shift;
        logic              below_zero;
        logic              emit;
        logic [ADDR_W-1:0] emit_row;
        logic              emit_last;
    } ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/lae_ctrl.sv
// ---------------------------------------------------------------------------
// lae_ctrl - sequencer for the row sweep
// Takes a valid command, then steps a row counter through reads, window
// shifts and row emission until the last row has gone out.
// ---------------------------------------------------------------------------
`default_nettype none

module lae_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          cmd_ok,
    output lae_pkg::ctl_t      ctl,
    output logic               busy
);

    lae_pkg::state_t                state_reg, state_next;
    logic [lae_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [lae_pkg::CNT_W-1:0]      emit_cnt;

    localparam logic [lae_pkg::CNT_W-1:0] CNT_ROWS = lae_pkg::CNT_W'(lae_pkg::GRID_SIZE);
    localparam logic [lae_pkg::CNT_W-1:0] CNT_END  = lae_pkg::CNT_W'(lae_pkg::GRID_SIZE + 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lae_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign emit_cnt = cnt_reg - lae_pkg::CNT_W'(2);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ctl            = '0;
        busy           = 1'b0;
        ctl.read_addr  = cnt_reg[lae_pkg::ADDR_W-1:0];
        ctl.emit_row   = emit_cnt[lae_pkg::ADDR_W-1:0];
        unique case (state_reg)
            lae_pkg::ST_IDLE:
            begin
                if (start && cmd_ok)
                begin
                    ctl.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = lae_pkg::ST_SWEEP;
                end
            end
            lae_pkg::ST_SWEEP:
            begin
                busy           = 1'b1;
                // count k: read row k, window takes row k-1, row k-2 goes out
                ctl.read_en    = (cnt_reg < CNT_ROWS);
                ctl.shift      = (cnt_reg != '0);
                ctl.below_zero = (cnt_reg == CNT_END);
                ctl.emit       = (cnt_reg >= lae_pkg::CNT_W'(2));
                ctl.emit_last  = (cnt_reg == CNT_END);
                cnt_next       = cnt_reg + lae_pkg::CNT_W'(1);
                if (cnt_reg == CNT_END)
                begin
                    state_next = lae_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lae_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/lae_datapath.sv
// ---------------------------------------------------------------------------
// lae_datapath - grid store, three-row window and row update
// Holds the grid in a row memory with per-row valid bits, builds each new
// row from the window and writes it back in place while it is emitted.
// ---------------------------------------------------------------------------
`default_nettype none

module lae_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lae_pkg::cmd_item_t command,
    input  wire lae_pkg::ctl_t      ctl,
    output logic                    cmd_ok,
    output lae_pkg::result_t        result,
    output logic                    strobe
);

    localparam int RW = lae_pkg::ROW_W;

    logic [RW-1:0]                  mem [lae_pkg::GRID_SIZE];
    logic [lae_pkg::GRID_SIZE-1:0]  valid_reg;
    logic [RW-1:0]                  mem_q_reg;
    logic                           mem_q_valid_reg;
    logic [RW-1:0]                  rd_row;

    logic [1:0]                     op_reg;
    logic [lae_pkg::IDX_W-1:0]      row_reg;
    logic [lae_pkg::IDX_W-1:0]      col_reg;
    logic [RW-1:0]                  above_reg;
    logic [RW-1:0]                  here_reg;

    logic [RW-1:0]                  below;
    logic [RW-1:0]                  new_row;
    logic [RW-1:0]                  col_bit;
    logic                           hit;
    logic [lae_pkg::WIDE_W-1:0]     wide_row;

    lae_pkg::result_t               result_reg;
    logic                           strobe_reg;

    // B3/S23 on one row; cells past either edge are dead
    function automatic logic [RW-1:0] life_row(
        input logic [RW-1:0] up,
        input logic [RW-1:0] mid,
        input logic [RW-1:0] dn
    );
        logic [RW+1:0] u;
        logic [RW+1:0] m;
        logic [RW+1:0] d;
        logic [3:0]    n;
        logic [RW-1:0] res;
        u = {1'b0, up, 1'b0};
        m = {1'b0, mid, 1'b0};
        d = {1'b0, dn, 1'b0};
        for (int c = 0; c < RW; c++)
        begin
            n = 4'(u[c]) + 4'(u[c+1]) + 4'(u[c+2])
              + 4'(m[c]) + 4'(m[c+2])
              + 4'(d[c]) + 4'(d[c+1]) + 4'(d[c+2]);
            res[c] = (n == 4'd3) || (m[c+1] && (n == 4'd2));
        end
        return res;
    endfunction

    always_comb
    begin
        cmd_ok = 1'b0;
        unique case (command.cmd)
            lae_pkg::CMD_STEP:
            begin
                cmd_ok = 1'b1;
            end
            lae_pkg::CMD_SET, lae_pkg::CMD_CLEAR:
            begin
                cmd_ok = ({1'b0, command.cell_row} < 7'(lae_pkg::GRID_SIZE))
                      && ({1'b0, command.cell_col} < 7'(lae_pkg::GRID_SIZE));
            end
            default:
            begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    // grid row memory
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            mem[ctl.emit_row] <= new_row;
        end
        if (ctl.read_en)
        begin
            mem_q_reg <= mem[ctl.read_addr];
        end
    end

    // rows never written read as dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            mem_q_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.emit)
            begin
                valid_reg[ctl.emit_row] <= 1'b1;
            end
            if (ctl.read_en)
            begin
                mem_q_valid_reg <= valid_reg[ctl.read_addr];
            end
        end
    end

    assign rd_row = mem_q_valid_reg ? mem_q_reg : '0;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg    <= command.cmd;
            row_reg   <= command.cell_row;
            col_reg   <= command.cell_col;
            above_reg <= '0;
            here_reg  <= '0;
        end
        else if (ctl.shift)
        begin
            above_reg <= here_reg;
            here_reg  <= below;
        end
    end

    assign below   = ctl.below_zero ? '0 : rd_row;
    assign col_bit = RW'(1) << col_reg;
    assign hit     = (lae_pkg::IDX_W'(ctl.emit_row) == row_reg);

    always_comb
    begin
        new_row = here_reg;
        priority if (op_reg == lae_pkg::CMD_STEP)
        begin
            new_row = life_row(above_reg, here_reg, below);
        end
        else if (hit && (op_reg == lae_pkg::CMD_SET))
        begin
            new_row = here_reg | col_bit;
        end
        else if (hit)
        begin
            new_row = here_reg & ~col_bit;
        end
        else
        begin
            new_row = here_reg;
        end
    end

    assign wide_row = lae_pkg::WIDE_W'(new_row);

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            result_reg.row_index <= lae_pkg::IDX_W'(ctl.emit_row);
            result_reg.row_cells <= wide_row[lae_pkg::OUT_W-1:0];
            result_reg.last_row  <= ctl.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.emit;
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

`default_nettype wire

FILE: hdl/life_automaton_engine.sv
// ---------------------------------------------------------------------------
// life_automaton_engine - bounded-grid Game of Life engine, B3/S23
// Set cell, clear cell or advance one generation, then emit every row.
// ---------------------------------------------------------------------------
// After the command transfer the rows are read, shifted through the window and
//   registered out in order, one row per cycle; busy is high for the whole sweep.
// Rate is set by the single read port of the row memory: one row a cycle.
// Invalid commands are dropped with busy staying low; the receiver cannot
//   stall, each row is on the result ports for one cycle with strobe.
// Reset clears the grid to all dead at once via per-row valid bits.
`default_nettype none

module life_automaton_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire lae_pkg::cmd_item_t command,
    output logic                    busy,
    output lae_pkg::result_t        result,
    output logic                    strobe
);

    lae_pkg::ctl_t ctl;
    logic          cmd_ok;

    lae_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd_ok (cmd_ok),
        .ctl    (ctl),
        .busy   (busy)
    );

    lae_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (command),
        .ctl     (ctl),
        .cmd_ok  (cmd_ok),
        .result  (result),
        .strobe  (strobe)
    );

endmodule

`default_nettype wire
